>>> hdl/lmsf_pkg.sv
package lmsf_pkg;

  // Sample domain: 1.0 equals 2^15
  localparam int unsigned SAMPLE_FRAC = 15;

  // Shared multiplier widths: 32-bit signed by 17-bit signed
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // Adaptation step after reset
  localparam logic [15:0] STEP_RESET = 16'd655;

  // Output saturation limits
  localparam logic signed [31:0] OUT_MAX = 32'sd32767;
  localparam logic signed [31:0] OUT_MIN = -32'sd32768;

  // Multiplier operations
  localparam logic [1:0] MAC_WS = 2'd0;  // weight * sample
  localparam logic [1:0] MAC_ES = 2'd1;  // error * sample
  localparam logic [1:0] MAC_GS = 2'd2;  // gradient * step

  typedef struct packed {
    logic       en;
    logic [1:0] op;
  } mac_ctl_t;

endpackage

>>> hdl/lmsf_in_if.sv
interface lmsf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic signed [15:0] reference;

  modport source (output valid, output sample, output reference, input ready);
  modport sink   (input valid, input sample, input reference, output ready);
endinterface

>>> hdl/lmsf_out_if.sv
interface lmsf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] filtered;
  logic signed [31:0] error;

  modport source (output valid, output filtered, output error, input ready);
  modport sink   (input valid, input filtered, input error, output ready);
endinterface

>>> hdl/lmsf_cfg_if.sv
interface lmsf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] adapt_step;

  modport source (output valid, output adapt_step, input ready);
  modport sink   (input valid, input adapt_step, output ready);
endinterface

>>> hdl/lms_adaptive_fir.sv
// Channel  Dir  Payload                               Transfer
// in_ch    in   sample[15:0] s, reference[15:0] s     valid & ready
// out_ch   out  filtered[15:0] s, error[31:0] s       valid & ready
// cfg_ch   in   adapt_step[15:0] u                    valid & ready (always ready)
//
// One multiplier is shared by a pipelined filter pass (one tap per cycle) and
// an update pass of three steps per tap (two dependent products and a weight
// write-back).
// in_ready is high only when the sequencer is idle; a finished result sits in
// the output register while the next item is taken. Synchronous reset clears
// the weights and delay line through per-entry valid bits, at once.
module lms_adaptive_fir #(
  parameter int unsigned TAPS      = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  lmsf_in_if.sink     in_ch,
  lmsf_out_if.source  out_ch,
  lmsf_cfg_if.sink    cfg_ch
);
  import lmsf_pkg::*;

  localparam int unsigned IDX_W = $clog2(TAPS);
  localparam int unsigned SCALE_SHIFT = FRAC_BITS - SAMPLE_FRAC;
  localparam logic [31:0] TRUNC_MASK = (32'd1 << SCALE_SHIFT) - 32'd1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIR   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_M1    = 3'd3;
  localparam logic [2:0] S_M2    = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic              v1_r, v1_nxt;
  logic              v2_r;
  logic [TAPS-1:0]   w_vld_r, s_vld_r;
  logic [15:0]       step_r;
  logic signed [31:0] acc_r;
  logic signed [31:0] err_r;
  logic signed [15:0] ref_r;
  logic              out_valid_r;
  logic signed [15:0] filt_r;
  logic signed [31:0] out_err_r;

  logic signed [31:0] wmem [TAPS];
  logic signed [15:0] smem [TAPS];
  logic signed [31:0] rd_w_r;
  logic signed [15:0] rd_s_r;
  logic              rd_wv_r, rd_sv_r;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_j, rd_idx;

  logic              in_xfer, out_free, wr_en;
  logic [IDX_W-1:0]  idx_dec, pos_inc;
  logic signed [31:0] w_cur, new_w, err_c, ref_scaled, q_sh, q_trunc;
  logic signed [15:0] s_cur, filt_c;
  logic signed [31:0] prod_q15, prod_frac;
  mac_ctl_t          mac_ctl;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign idx_dec  = (idx_r == '0) ? LAST_IDX : idx_r - 1'b1;
  assign pos_inc  = (pos_r == LAST_IDX) ? '0 : pos_r + 1'b1;

  // Entries never written read as zero
  assign w_cur = rd_wv_r ? rd_w_r : '0;
  assign s_cur = rd_sv_r ? rd_s_r : '0;
  assign new_w = w_cur + prod_frac;
  assign wr_en = (state_r == S_WR);

  // Error against the reference in filter scale
  assign ref_scaled = 32'(ref_r) <<< SCALE_SHIFT;
  assign err_c      = ref_scaled - acc_r;

  // Output rescale: truncate toward zero, then saturate
  assign q_sh    = acc_r >>> SCALE_SHIFT;
  assign q_trunc = (acc_r[31] && ((acc_r & TRUNC_MASK) != '0)) ? q_sh + 32'sd1 : q_sh;
  always_comb begin
    if (q_trunc > OUT_MAX) begin
      filt_c = OUT_MAX[15:0];
    end else if (q_trunc < OUT_MIN) begin
      filt_c = OUT_MIN[15:0];
    end else begin
      filt_c = q_trunc[15:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    v1_nxt    = 1'b0;
    rd_en     = 1'b0;
    rd_j      = j_r;
    rd_idx    = idx_r;
    mac_ctl   = '{en: 1'b0, op: MAC_WS};
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          j_nxt     = '0;
          idx_nxt   = pos_r;
          state_nxt = S_FIR;
        end
      end
      S_FIR: begin
        rd_en  = 1'b1;
        v1_nxt = 1'b1;
        if (j_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          j_nxt   = j_r + 1'b1;
          idx_nxt = idx_dec;
        end
      end
      S_DRAIN: begin
        if (!v1_r && !v2_r) begin
          rd_en     = 1'b1;
          rd_j      = '0;
          rd_idx    = pos_r;
          j_nxt     = '0;
          idx_nxt   = pos_r;
          state_nxt = S_M1;
        end
      end
      S_M1: begin
        mac_ctl   = '{en: 1'b1, op: MAC_ES};
        state_nxt = S_M2;
      end
      S_M2: begin
        mac_ctl   = '{en: 1'b1, op: MAC_GS};
        state_nxt = S_WR;
      end
      S_WR: begin
        if (j_r == LAST_IDX) begin
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_j      = j_r + 1'b1;
          rd_idx    = idx_dec;
          j_nxt     = j_r + 1'b1;
          idx_nxt   = idx_dec;
          state_nxt = S_M1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          pos_nxt   = pos_inc;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // Filter products start in the cycle after each filter read, when its data is out
    if (v1_r) begin
      mac_ctl = '{en: 1'b1, op: MAC_WS};
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      j_r         <= '0;
      idx_r       <= '0;
      pos_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      w_vld_r     <= '0;
      s_vld_r     <= '0;
      step_r      <= STEP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      idx_r   <= idx_nxt;
      pos_r   <= pos_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v1_r;
      if (in_xfer) begin
        s_vld_r[pos_r] <= 1'b1;
      end
      if (wr_en) begin
        w_vld_r[j_r] <= 1'b1;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        step_r <= cfg_ch.adapt_step;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      acc_r <= '0;
      ref_r <= in_ch.reference;
    end else if (v2_r) begin
      acc_r <= acc_r + prod_q15;
    end
    if (state_r == S_DRAIN && !v1_r && !v2_r) begin
      err_r <= err_c;
    end
    if (state_r == S_DONE && out_free) begin
      filt_r    <= filt_c;
      out_err_r <= err_r;
    end
  end

  // Delay line memory
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      smem[pos_r] <= in_ch.sample;
    end
    if (rd_en) begin
      rd_s_r  <= smem[rd_idx];
      rd_sv_r <= s_vld_r[rd_idx];
    end
  end

  // Coefficient memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      wmem[j_r] <= new_w;
    end
    if (rd_en) begin
      rd_w_r  <= wmem[rd_j];
      rd_wv_r <= w_vld_r[rd_j];
    end
  end

  lmsf_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .ctl       (mac_ctl),
    .weight    (w_cur),
    .err       (err_r),
    .smp       (s_cur),
    .step      (step_r),
    .prod_q15  (prod_q15),
    .prod_frac (prod_frac)
  );

  assign in_ch.ready     = (state_r == S_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.filtered = filt_r;
  assign out_ch.error    = out_err_r;

  // Checks
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_FIR)
    else $error("accepted item did not start the filter pass");

  a_pipe_fir: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (state_r == S_FIR || state_r == S_DRAIN))
    else $error("filter product outside the filter pass");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> !in_ch.ready)
    else $error("ready while filter reads are in flight");

  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished item not presented");

  a_update_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> $past(state_r) == S_M2)
    else $error("weight write without both products");

endmodule

>>> hdl/lmsf_mac.sv
module lmsf_mac #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk,
  input  lmsf_pkg::mac_ctl_t     ctl,
  input  logic signed [31:0]     weight,
  input  logic signed [31:0]     err,
  input  logic signed [15:0]     smp,
  input  logic        [15:0]     step,
  output logic signed [31:0]     prod_q15,
  output logic signed [31:0]     prod_frac
);
  import lmsf_pkg::*;

  logic signed [MUL_A_W-1:0] a_sel;
  logic signed [MUL_B_W-1:0] b_sel;
  logic signed [PROD_W-1:0]  prod_c;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  prod_sh;

  // Operand select; the gradient comes back from the product register
  always_comb begin
    case (ctl.op)
      MAC_WS: begin
        a_sel = weight;
        b_sel = MUL_B_W'(smp);
      end
      MAC_ES: begin
        a_sel = err;
        b_sel = MUL_B_W'(smp);
      end
      MAC_GS: begin
        a_sel = prod_q15;
        b_sel = $signed({1'b0, step});
      end
      default: begin
        a_sel = '0;
        b_sel = '0;
      end
    endcase
  end

  assign prod_c = a_sel * b_sel;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= prod_c;
    end
  end

  // Floor shifts, wrapped to 32 bits
  assign prod_q15  = prod_r[SAMPLE_FRAC+31:SAMPLE_FRAC];
  assign prod_sh   = prod_r >>> FRAC_BITS;
  assign prod_frac = prod_sh[31:0];

endmodule

>>> sim/tb_lms_adaptive_fir.sv
`timescale 1ns / 100ps

module tb_lms_adaptive_fir;
  import lmsf_pkg::*;

  localparam int TAPS_N      = 32;
  localparam int FRAC_N      = 16;
  localparam int TAP_SHIFT   = FRAC_N - int'(SAMPLE_FRAC);
  localparam int ITEM_CYCLES = 4 * TAPS_N + 5;
  localparam int SETTLE      = 2 * ITEM_CYCLES;
  localparam int STALL_LIMIT = 4000;

  typedef enum int {PACE_SINK_HEAVY, PACE_SOURCE_HEAVY, PACE_FULL} pace_t;

  typedef struct {
    logic signed [15:0] sample;
    logic signed [15:0] reference;
  } sample_pair_t;

  typedef struct {
    logic signed [15:0] filtered;
    logic signed [31:0] error;
  } lms_result_t;

  logic clk;
  logic rst_n;

  lmsf_in_if  in_if ();
  lmsf_out_if out_if ();
  lmsf_cfg_if cfg_if ();

  lms_adaptive_fir #(
    .TAPS      (TAPS_N),
    .FRAC_BITS (FRAC_N)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Stimulus and bookkeeping
  sample_pair_t sample_pairs_q[$];
  lms_result_t  filtered_error_q[$];
  pace_t        pace;
  int           items_queued;
  int           results_seen;
  int           fails;
  int           stall_cycles;
  logic         in_took;

  // Predictor state
  logic signed [31:0] coef [TAPS_N];
  logic signed [31:0] tap_hist [TAPS_N];
  int unsigned        head;
  logic [15:0]        step_now;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor(a*b / 2^FRAC), wrapped to 32 bits
  function automatic logic signed [31:0] fx_product(longint a, longint b);
    longint p;
    p = (a * b) >>> FRAC_N;
    return 32'(p);
  endfunction

  // One filter step: output, error, and weight update
  function automatic lms_result_t lms_filter_update(logic signed [15:0] s,
                                                    logic signed [15:0] r);
    int unsigned        slot;
    logic signed [31:0] acc;
    logic signed [31:0] err;
    logic signed [31:0] grad;
    longint             q;
    lms_result_t        res;
    slot = head;
    tap_hist[slot] = 32'(longint'(s) <<< TAP_SHIFT);
    acc = '0;
    for (int j = 0; j < TAPS_N; j++)
      acc = acc + fx_product(coef[j], tap_hist[(slot + TAPS_N - j) % TAPS_N]);
    err = 32'((longint'(r) <<< TAP_SHIFT) - longint'(acc));
    for (int j = 0; j < TAPS_N; j++) begin
      grad = fx_product(err, tap_hist[(slot + TAPS_N - j) % TAPS_N]);
      coef[j] = coef[j] + fx_product(longint'(step_now), grad);
    end
    // divide truncates toward zero, then saturate to 16 bits
    q = longint'(acc) / (longint'(1) <<< TAP_SHIFT);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    res.filtered = 16'(q);
    res.error    = err;
    head = (slot + 1) % TAPS_N;
    return res;
  endfunction

  function automatic int source_idle_pct(pace_t p);
    case (p)
      PACE_SINK_HEAVY:   return 25;
      PACE_SOURCE_HEAVY: return 60;
      default:           return 0;
    endcase
  endfunction

  function automatic int sink_idle_pct(pace_t p);
    case (p)
      PACE_SINK_HEAVY:   return 60;
      PACE_SOURCE_HEAVY: return 25;
      default:           return 0;
    endcase
  endfunction

  // Driver: next transfer on the input channel, random ready on the output
  always @(negedge clk) begin : drive_in
    sample_pair_t nxt;
    logic         send;
    if (!rst_n) begin
      in_if.valid  <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      if (!in_if.valid || in_took) begin
        send = (sample_pairs_q.size() > 0) &&
               ($urandom_range(0, 99) >= source_idle_pct(pace));
        if (send) begin
          nxt = sample_pairs_q.pop_front();
          in_if.valid     <= 1'b1;
          in_if.sample    <= nxt.sample;
          in_if.reference <= nxt.reference;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct(pace));
    end
  end

  // Monitor: check results first, then predict for accepted inputs
  always @(posedge clk) begin : watch_ports
    lms_result_t want;
    if (!rst_n) begin
      for (int j = 0; j < TAPS_N; j++) begin
        coef[j]     = '0;
        tap_hist[j] = '0;
      end
      head     = 0;
      step_now = STEP_RESET;
      in_took <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (filtered_error_q.size() == 0) begin
          $display("%0t: unexpected result filtered=%0d error=%0d", $time,
                   out_if.filtered, out_if.error);
          fails++;
        end else begin
          want = filtered_error_q.pop_front();
          if (out_if.filtered !== want.filtered) begin
            $display("%0t: filtered mismatch expected %0d actual %0d", $time,
                     want.filtered, out_if.filtered);
            fails++;
          end
          if (out_if.error !== want.error) begin
            $display("%0t: error mismatch expected %0d actual %0d", $time,
                     want.error, out_if.error);
            fails++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready)
        step_now = cfg_if.adapt_step;
      if (in_if.valid && in_if.ready)
        filtered_error_q.push_back(lms_filter_update(in_if.sample, in_if.reference));
      in_took <= in_if.valid && in_if.ready;
    end
  end

  // Watchdog: too long without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
        $display("lms_adaptive_fir regression: fail");
        $finish;
      end
    end else begin
      stall_cycles <= 0;
    end
  end

  task automatic add_pair(int s, int r);
    sample_pair_t p;
    p.sample    = 16'(s);
    p.reference = 16'(r);
    sample_pairs_q.push_back(p);
    items_queued++;
  endtask

  function automatic int extreme16();
    case ($urandom_range(0, 3))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  // Random runs; most are an echo path the filter can learn
  task automatic add_random(int n);
    int left, kind, run, amp, dly, gain, s, r;
    int hist [16];
    left = n;
    foreach (hist[k]) hist[k] = 0;
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      run  = $urandom_range(8, 40);
      if (run > left) run = left;
      amp  = $urandom_range(0, 12);
      dly  = $urandom_range(0, 15);
      gain = $urandom_range(1, 8);
      for (int k = 0; k < run; k++) begin
        if (kind <= 5) begin
          // echo of an earlier sample plus a little noise
          s = (int'($urandom_range(0, 65535)) - 32768) >>> amp;
          r = ((hist[dly] * gain) >>> 3) + int'($urandom_range(0, 15)) - 8;
          if (r > 32767) r = 32767;
          if (r < -32768) r = -32768;
        end else if (kind == 6) begin
          // no reference present
          s = $urandom_range(0, 65535) - 32768;
          r = 0;
        end else if (kind == 7) begin
          s = $urandom_range(0, 65535) - 32768;
          r = $urandom_range(0, 65535) - 32768;
        end else if (kind == 8) begin
          s = extreme16();
          r = extreme16();
        end else begin
          s = 0;
          r = (int'($urandom_range(0, 65535)) - 32768) >>> amp;
        end
        for (int k2 = 15; k2 > 0; k2--) hist[k2] = hist[k2 - 1];
        hist[0] = s;
        add_pair(s, r);
      end
      left -= run;
    end
  endtask

  // Wait for every result; each update pass has finished by the time its result is out
  task automatic wait_drained();
    while (results_seen != items_queued) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_step(logic [15:0] v);
    @(negedge clk);
    cfg_if.valid      <= 1'b1;
    cfg_if.adapt_step <= v;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    in_if.valid       = 1'b0;
    in_if.sample      = '0;
    in_if.reference   = '0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.adapt_step = '0;
    items_queued      = 0;
    results_seen      = 0;
    fails             = 0;
    pace              = PACE_SINK_HEAVY;
    rst_n             = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, absent reference, steady and alternating drive
    add_pair(0, 0);
    add_pair(32767, 32767);
    add_pair(-32768, -32768);
    add_pair(32767, -32768);
    add_pair(-32768, 32767);
    add_pair(1, 0);
    add_pair(-1, 0);
    add_pair(21845, -21846);
    for (int k = 0; k < 8; k++) add_pair(32767, 32767);
    for (int k = 0; k < 6; k++) add_pair((k % 2) ? 32767 : -32768, -32768);
    add_random(300);
    wait_drained();

    // Step of zero freezes the weights
    write_step(16'd0);
    add_random(150);
    wait_drained();

    // Step of almost 1.0 drives weights, sum and error into wrap-around
    pace = PACE_SOURCE_HEAVY;
    write_step(16'hFFFF);
    add_random(250);
    wait_drained();

    write_step(16'($urandom_range(1, 65534)));
    add_random(200);
    wait_drained();

    pace = PACE_FULL;
    write_step(16'd1);
    add_random(200);
    wait_drained();

    write_step(STEP_RESET);
    add_random(250);
    wait_drained();

    if (filtered_error_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               filtered_error_q.size());
      fails++;
    end
    if (fails == 0)
      $display("lms_adaptive_fir regression: pass");
    else
      $display("lms_adaptive_fir regression: fail");
    $finish;
  end

endmodule

>>> files.f
hdl/lmsf_pkg.sv
hdl/lmsf_in_if.sv
hdl/lmsf_out_if.sv
hdl/lmsf_cfg_if.sv
hdl/lmsf_mac.sv
hdl/lms_adaptive_fir.sv
sim/tb_lms_adaptive_fir.sv
